// ===== src/dpv_pkg.sv =====
// package for the distance pid velocity block: codes, widths and reset values
`default_nettype none
package dpv_pkg;

	localparam int SUM_WIDTH_DEF = 48;
	localparam int GAIN_W        = 16;
	localparam int LIMIT_W       = 31;
	localparam int POS_W         = 32;
	localparam int ROOT_W        = 33;
	localparam int RAD_W         = 2 * ROOT_W;
	localparam int REM_W         = ROOT_W + 1;
	localparam int MUL_W         = ROOT_W + 1;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int LAST_W        = 34;
	localparam int GAIN_SHIFT    = 8;
	localparam int CHUNK_W       = 32;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_LIMIT = 2'd3;

	localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 16'd256;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 16'd0;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 16'd0;
	localparam logic [LIMIT_W-1:0] VEL_LIMIT_RST = 31'd19661;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_SQ_ADD,
		ST_SQ_LOAD,
		ST_SQRT,
		ST_INTEG,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_ACC_END,
		ST_CLAMP
	} state_t;

endpackage
`default_nettype wire

// ===== src/distance_pid_velocity.sv =====
// top level: pid velocity controller on the euclidean distance to a goal
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_stall   current_x, current_y, goal_x, goal_y
//  out       output     out_valid / out_stall velocity, clamped
//  cfg       input      cfg_write             cfg_index, cfg_data
//
// the square root works one bit per cycle (33 steps), and one shared
// 34x34 multiplier forms the squares and the gain terms, one per cycle
// in_stall is high from the transfer until the result is loaded into the output register
// a new item is taken while the last result still waits; the block holds before loading
// the next result while out_stall keeps the previous one
// reset clears the integrator, the previous error and the gains to their defaults
`default_nettype none
module distance_pid_velocity #(
	parameter int SUM_WIDTH = dpv_pkg::SUM_WIDTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_write,
	input  wire  [dpv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [dpv_pkg::LIMIT_W-1:0]         cfg_data,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  signed [dpv_pkg::POS_W-1:0]    current_x,
	input  wire  signed [dpv_pkg::POS_W-1:0]    current_y,
	input  wire  signed [dpv_pkg::POS_W-1:0]    goal_x,
	input  wire  signed [dpv_pkg::POS_W-1:0]    goal_y,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic signed [dpv_pkg::POS_W-1:0]    velocity,
	output logic                                clamped
);

	localparam int CHUNKS = (SUM_WIDTH + dpv_pkg::CHUNK_W - 1) / dpv_pkg::CHUNK_W;
	localparam int CIW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int PADW   = CHUNKS * dpv_pkg::CHUNK_W;
	localparam int ACC_W  = PADW + 20;
	localparam int CNT_W  = $clog2(dpv_pkg::ROOT_W);

	dpv_pkg::state_t state_q, state_d;

	logic [dpv_pkg::GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic [dpv_pkg::LIMIT_W-1:0] vel_limit_q;

	logic [dpv_pkg::POS_W-1:0]   ax_q, ay_q;
	logic signed [dpv_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic signed [dpv_pkg::PROD_W-1:0] prod_q;
	logic                        pend_q, pend_en;
	logic [CIW-1:0]              pend_idx_q, pend_idx_d;
	logic signed [ACC_W-1:0]     acc_q, acc_add;

	logic [dpv_pkg::RAD_W-1:0]   rad_q;
	logic [dpv_pkg::REM_W-1:0]   rem_q;
	logic [dpv_pkg::ROOT_W-1:0]  root_q, e_q;
	logic [CNT_W-1:0]            sqrt_cnt_q;
	logic [dpv_pkg::REM_W+1:0]   rem_sh, trial;
	logic                        take;

	logic [SUM_WIDTH-1:0]        error_sum_q;
	logic [SUM_WIDTH:0]          sum_ext;
	logic [PADW-1:0]             sum_pad;
	logic [dpv_pkg::CHUNK_W-1:0] chunk;
	logic [CIW-1:0]              chunk_cnt_q;
	logic [dpv_pkg::LAST_W-1:0]  last_error_q;
	logic signed [dpv_pkg::LAST_W-1:0] d_q;

	logic signed [dpv_pkg::POS_W:0] dx, dy;
	logic signed [ACC_W-1:0]     hi_lim, lo_lim;
	logic                        out_free;

	logic signed [dpv_pkg::POS_W-1:0] velocity_q;
	logic                        clamped_q, out_valid_q;

	// per-axis difference between goal and current position
	assign dx = $signed({goal_x[dpv_pkg::POS_W-1], goal_x})
	          - $signed({current_x[dpv_pkg::POS_W-1], current_x});
	assign dy = $signed({goal_y[dpv_pkg::POS_W-1], goal_y})
	          - $signed({current_y[dpv_pkg::POS_W-1], current_y});

	assign sum_pad  = PADW'(error_sum_q);
	assign chunk    = sum_pad[chunk_cnt_q*dpv_pkg::CHUNK_W +: dpv_pkg::CHUNK_W];
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != dpv_pkg::ST_IDLE);

	// square root step
	assign rem_sh = {rem_q, rad_q[dpv_pkg::RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = (rem_sh >= trial);

	assign sum_ext = {1'b0, error_sum_q} + (SUM_WIDTH+1)'(root_q);
	assign acc_add = ACC_W'(prod_q) <<< (pend_idx_q * dpv_pkg::CHUNK_W);

	assign hi_lim = ACC_W'(vel_limit_q) <<< dpv_pkg::GAIN_SHIFT;
	assign lo_lim = -hi_lim;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dpv_pkg::ST_IDLE:    if (in_valid) state_d = dpv_pkg::ST_MUL_X;
			dpv_pkg::ST_MUL_X:   state_d = dpv_pkg::ST_MUL_Y;
			dpv_pkg::ST_MUL_Y:   state_d = dpv_pkg::ST_SQ_ADD;
			dpv_pkg::ST_SQ_ADD:  state_d = dpv_pkg::ST_SQ_LOAD;
			dpv_pkg::ST_SQ_LOAD: state_d = dpv_pkg::ST_SQRT;
			dpv_pkg::ST_SQRT:    if (sqrt_cnt_q == '0) state_d = dpv_pkg::ST_INTEG;
			dpv_pkg::ST_INTEG:   state_d = dpv_pkg::ST_MUL_P;
			dpv_pkg::ST_MUL_P:   state_d = dpv_pkg::ST_MUL_I;
			dpv_pkg::ST_MUL_I:   if (chunk_cnt_q == CIW'(CHUNKS - 1)) state_d = dpv_pkg::ST_MUL_D;
			dpv_pkg::ST_MUL_D:   state_d = dpv_pkg::ST_ACC_END;
			dpv_pkg::ST_ACC_END: state_d = dpv_pkg::ST_CLAMP;
			dpv_pkg::ST_CLAMP:   if (out_free) state_d = dpv_pkg::ST_IDLE;
			default:             state_d = dpv_pkg::ST_IDLE;
		endcase
	end

	// multiplier operand select
	always_comb begin
		mul_a      = '0;
		mul_b      = '0;
		pend_en    = 1'b0;
		pend_idx_d = '0;
		unique case (state_q)
			dpv_pkg::ST_MUL_X: begin
				mul_a   = $signed(dpv_pkg::MUL_W'(ax_q));
				mul_b   = $signed(dpv_pkg::MUL_W'(ax_q));
				pend_en = 1'b1;
			end
			dpv_pkg::ST_MUL_Y: begin
				mul_a   = $signed(dpv_pkg::MUL_W'(ay_q));
				mul_b   = $signed(dpv_pkg::MUL_W'(ay_q));
				pend_en = 1'b1;
			end
			dpv_pkg::ST_MUL_P: begin
				mul_a   = dpv_pkg::MUL_W'($signed(gain_p_q));
				mul_b   = $signed(dpv_pkg::MUL_W'(e_q));
				pend_en = 1'b1;
			end
			dpv_pkg::ST_MUL_I: begin
				mul_a      = dpv_pkg::MUL_W'($signed(gain_i_q));
				mul_b      = $signed(dpv_pkg::MUL_W'(chunk));
				pend_en    = 1'b1;
				pend_idx_d = chunk_cnt_q;
			end
			dpv_pkg::ST_MUL_D: begin
				mul_a   = dpv_pkg::MUL_W'($signed(gain_d_q));
				mul_b   = dpv_pkg::MUL_W'(d_q);
				pend_en = 1'b1;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dpv_pkg::ST_IDLE;
			gain_p_q     <= dpv_pkg::GAIN_P_RST;
			gain_i_q     <= dpv_pkg::GAIN_I_RST;
			gain_d_q     <= dpv_pkg::GAIN_D_RST;
			vel_limit_q  <= dpv_pkg::VEL_LIMIT_RST;
			pend_q       <= 1'b0;
			pend_idx_q   <= '0;
			sqrt_cnt_q   <= '0;
			chunk_cnt_q  <= '0;
			error_sum_q  <= '0;
			last_error_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			pend_q     <= pend_en;
			pend_idx_q <= pend_idx_d;
			if (cfg_write) begin
				unique case (cfg_index)
					dpv_pkg::REG_GAIN_P:    gain_p_q    <= cfg_data[dpv_pkg::GAIN_W-1:0];
					dpv_pkg::REG_GAIN_I:    gain_i_q    <= cfg_data[dpv_pkg::GAIN_W-1:0];
					dpv_pkg::REG_GAIN_D:    gain_d_q    <= cfg_data[dpv_pkg::GAIN_W-1:0];
					dpv_pkg::REG_VEL_LIMIT: vel_limit_q <= cfg_data;
					default:                gain_p_q    <= gain_p_q;
				endcase
			end
			if (state_q == dpv_pkg::ST_SQ_LOAD) begin
				sqrt_cnt_q <= CNT_W'(dpv_pkg::ROOT_W - 1);
			end else if (state_q == dpv_pkg::ST_SQRT) begin
				sqrt_cnt_q <= sqrt_cnt_q - 1'b1;
			end
			if (state_q == dpv_pkg::ST_INTEG) begin
				chunk_cnt_q <= '0;
				error_sum_q <= sum_ext[SUM_WIDTH] ? {SUM_WIDTH{1'b1}}
				                                  : sum_ext[SUM_WIDTH-1:0];
				last_error_q <= dpv_pkg::LAST_W'(root_q);
			end else if (state_q == dpv_pkg::ST_MUL_I) begin
				chunk_cnt_q <= chunk_cnt_q + 1'b1;
			end
			if (state_q == dpv_pkg::ST_CLAMP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == dpv_pkg::ST_IDLE && in_valid) begin
			ax_q <= dx[dpv_pkg::POS_W] ? dpv_pkg::POS_W'(-dx) : dx[dpv_pkg::POS_W-1:0];
			ay_q <= dy[dpv_pkg::POS_W] ? dpv_pkg::POS_W'(-dy) : dy[dpv_pkg::POS_W-1:0];
		end
		if ((state_q == dpv_pkg::ST_IDLE) || (state_q == dpv_pkg::ST_INTEG)) begin
			acc_q <= '0;
		end else if (pend_q) begin
			acc_q <= acc_q + acc_add;
		end
		if (state_q == dpv_pkg::ST_SQ_LOAD) begin
			rad_q  <= acc_q[dpv_pkg::RAD_W-1:0];
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == dpv_pkg::ST_SQRT) begin
			rad_q  <= {rad_q[dpv_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= take ? dpv_pkg::REM_W'(rem_sh - trial) : rem_sh[dpv_pkg::REM_W-1:0];
			root_q <= {root_q[dpv_pkg::ROOT_W-2:0], take};
		end
		if (state_q == dpv_pkg::ST_INTEG) begin
			e_q <= root_q;
			d_q <= $signed(dpv_pkg::LAST_W'(root_q)) - $signed(last_error_q);
		end
		if (state_q == dpv_pkg::ST_CLAMP && out_free) begin
			if (acc_q > hi_lim) begin
				velocity_q <= $signed(dpv_pkg::POS_W'(vel_limit_q));
				clamped_q  <= 1'b1;
			end else if (acc_q < lo_lim) begin
				velocity_q <= -$signed(dpv_pkg::POS_W'(vel_limit_q));
				clamped_q  <= 1'b1;
			end else begin
				velocity_q <= acc_q[dpv_pkg::GAIN_SHIFT +: dpv_pkg::POS_W];
				clamped_q  <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign velocity  = velocity_q;
	assign clamped   = clamped_q;

	// the integrator only grows or holds between resets
	a_sum_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		error_sum_q >= $past(error_sum_q))
		else $error("integrator decreased");

	// a clamped result sits exactly on the limit
	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && clamped_q) |->
		(velocity_q == $signed(dpv_pkg::POS_W'(vel_limit_q)) ||
		 velocity_q == -$signed(dpv_pkg::POS_W'(vel_limit_q))))
		else $error("clamped velocity off the limit");

	// a fresh result only comes from the clamp step
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == dpv_pkg::ST_CLAMP))
		else $error("result raised outside the clamp step");

endmodule
`default_nettype wire
